@@ rtl/core/qmm_pkg.sv @@
// Shared types, constants and codes for the two-level logic minimizer.
package qmm_pkg;

    localparam int MAX_VARS_DEF   = 5;
    localparam int TERM_DEPTH_DEF = 128;
    localparam int PRIME_DEPTH    = 32;
    localparam int PRIME_AW       = 5;
    localparam int OUT_W          = 5;
    localparam int TABLE_W        = 32;
    localparam int VC_W           = 3;
    localparam int KIND_W         = 2;

    localparam logic [KIND_W-1:0] KIND_TERM  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FALSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRUE  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CONST,
        ST_LOAD,
        ST_LVL,
        ST_X_RD,
        ST_X_LAT,
        ST_Y_RD,
        ST_Y_CMP,
        ST_Z_RD,
        ST_Z_CMP,
        ST_Z_ADD,
        ST_P_RD,
        ST_P_CHK,
        ST_C_RD,
        ST_C_WR,
        ST_ESS,
        ST_SEL_INIT,
        ST_PR_HEAD,
        ST_PR_STEP,
        ST_PR_END,
        ST_EM_CHK,
        ST_EM_NONE,
        ST_EMIT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_CONST,
        OP_LOAD,
        OP_LVL,
        OP_X_RD,
        OP_X_LAT,
        OP_X_NEXT,
        OP_Y_RD,
        OP_Y_CMP,
        OP_Z_RD,
        OP_Z_CMP,
        OP_Z_ADD,
        OP_P_INIT,
        OP_P_RD,
        OP_P_CHK,
        OP_C_INIT,
        OP_C_RD,
        OP_C_WR,
        OP_C_END,
        OP_E_INIT,
        OP_ESS,
        OP_S_INIT,
        OP_PR_BEGIN,
        OP_PR_STEP,
        OP_PR_END,
        OP_PR_SKIP,
        OP_EM_INIT,
        OP_EM_NONE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic tbl_zero;
        logic tbl_full;
        logic i_last;
        logic x_done;
        logic y_done;
        logic z_done;
        logic merge_ok;
        logic z_match;
        logic c_done;
        logic merged;
        logic pz_done;
        logic ess_cur;
        logic sel_none;
        logic out_free;
    } status_t;

endpackage

@@ rtl/core/qmm_in_if.sv @@
// Input channel: one truth table and its variable count per beat.
interface qmm_in_if;
    logic                          valid;
    logic                          ready;
    logic [qmm_pkg::TABLE_W-1:0]   table_bits;
    logic [qmm_pkg::VC_W-1:0]      var_count;

    modport source (output valid, output table_bits, output var_count, input ready);
    modport sink   (input valid, input table_bits, input var_count, output ready);
endinterface

@@ rtl/core/qmm_out_if.sv @@
// Output channel: one product term per beat.
interface qmm_out_if;
    logic                         valid;
    logic                         ready;
    logic [qmm_pkg::OUT_W-1:0]    care_mask;
    logic [qmm_pkg::OUT_W-1:0]    literal_true;
    logic [qmm_pkg::KIND_W-1:0]   constant_kind;
    logic                         table_overflow;
    logic                         last_term;

    modport source (output valid, output care_mask, output literal_true,
                    output constant_kind, output table_overflow, output last_term,
                    input ready);
    modport sink   (input valid, input care_mask, input literal_true,
                    input constant_kind, input table_overflow, input last_term,
                    output ready);
endinterface

@@ rtl/core/qmm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module qmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/qmm_ctrl.sv @@
// Sequencer of the minimizer: walks the load, merge, prime, cover and emit phases.
module qmm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  qmm_pkg::status_t status,
    output qmm_pkg::op_t     op
);

    qmm_pkg::state_t state_reg;
    qmm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qmm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qmm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = qmm_pkg::ST_CHECK;
                end
            end
            qmm_pkg::ST_CHECK:
            begin
                if (status.tbl_zero || status.tbl_full)
                begin
                    state_next = qmm_pkg::ST_CONST;
                end
                else
                begin
                    state_next = qmm_pkg::ST_LOAD;
                end
            end
            qmm_pkg::ST_CONST:
            begin
                if (status.out_free)
                begin
                    state_next = qmm_pkg::ST_IDLE;
                end
            end
            qmm_pkg::ST_LOAD:
            begin
                if (status.i_last)
                begin
                    state_next = qmm_pkg::ST_LVL;
                end
            end
            qmm_pkg::ST_LVL:      state_next = qmm_pkg::ST_X_RD;
            qmm_pkg::ST_X_RD:
            begin
                state_next = status.x_done ? qmm_pkg::ST_P_RD : qmm_pkg::ST_X_LAT;
            end
            qmm_pkg::ST_X_LAT:    state_next = qmm_pkg::ST_Y_RD;
            qmm_pkg::ST_Y_RD:
            begin
                state_next = status.y_done ? qmm_pkg::ST_X_RD : qmm_pkg::ST_Y_CMP;
            end
            qmm_pkg::ST_Y_CMP:
            begin
                state_next = status.merge_ok ? qmm_pkg::ST_Z_RD : qmm_pkg::ST_Y_RD;
            end
            qmm_pkg::ST_Z_RD:
            begin
                state_next = status.z_done ? qmm_pkg::ST_Z_ADD : qmm_pkg::ST_Z_CMP;
            end
            qmm_pkg::ST_Z_CMP:
            begin
                state_next = status.z_match ? qmm_pkg::ST_Y_RD : qmm_pkg::ST_Z_RD;
            end
            qmm_pkg::ST_Z_ADD:    state_next = qmm_pkg::ST_Y_RD;
            qmm_pkg::ST_P_RD:
            begin
                if (!status.x_done)
                begin
                    state_next = qmm_pkg::ST_P_CHK;
                end
                else if (status.merged)
                begin
                    state_next = qmm_pkg::ST_C_RD;
                end
                else
                begin
                    state_next = qmm_pkg::ST_ESS;
                end
            end
            qmm_pkg::ST_P_CHK:    state_next = qmm_pkg::ST_P_RD;
            qmm_pkg::ST_C_RD:
            begin
                state_next = status.c_done ? qmm_pkg::ST_LVL : qmm_pkg::ST_C_WR;
            end
            qmm_pkg::ST_C_WR:     state_next = qmm_pkg::ST_C_RD;
            qmm_pkg::ST_ESS:
            begin
                if (status.i_last)
                begin
                    state_next = qmm_pkg::ST_SEL_INIT;
                end
            end
            qmm_pkg::ST_SEL_INIT: state_next = qmm_pkg::ST_PR_HEAD;
            qmm_pkg::ST_PR_HEAD:
            begin
                if (status.pz_done)
                begin
                    state_next = qmm_pkg::ST_EM_CHK;
                end
                else if (!status.ess_cur)
                begin
                    state_next = qmm_pkg::ST_PR_STEP;
                end
            end
            qmm_pkg::ST_PR_STEP:
            begin
                if (status.i_last)
                begin
                    state_next = qmm_pkg::ST_PR_END;
                end
            end
            qmm_pkg::ST_PR_END:   state_next = qmm_pkg::ST_PR_HEAD;
            qmm_pkg::ST_EM_CHK:
            begin
                state_next = status.sel_none ? qmm_pkg::ST_EM_NONE : qmm_pkg::ST_EMIT;
            end
            qmm_pkg::ST_EM_NONE:
            begin
                if (status.out_free)
                begin
                    state_next = qmm_pkg::ST_IDLE;
                end
            end
            qmm_pkg::ST_EMIT:
            begin
                if (status.pz_done)
                begin
                    state_next = qmm_pkg::ST_IDLE;
                end
            end
            default:              state_next = qmm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        op       = qmm_pkg::OP_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            qmm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op = qmm_pkg::OP_START;
                end
            end
            qmm_pkg::ST_CHECK:    op = qmm_pkg::OP_NONE;
            qmm_pkg::ST_CONST:    op = qmm_pkg::OP_CONST;
            qmm_pkg::ST_LOAD:     op = qmm_pkg::OP_LOAD;
            qmm_pkg::ST_LVL:      op = qmm_pkg::OP_LVL;
            qmm_pkg::ST_X_RD:
            begin
                op = status.x_done ? qmm_pkg::OP_P_INIT : qmm_pkg::OP_X_RD;
            end
            qmm_pkg::ST_X_LAT:    op = qmm_pkg::OP_X_LAT;
            qmm_pkg::ST_Y_RD:
            begin
                op = status.y_done ? qmm_pkg::OP_X_NEXT : qmm_pkg::OP_Y_RD;
            end
            qmm_pkg::ST_Y_CMP:    op = qmm_pkg::OP_Y_CMP;
            qmm_pkg::ST_Z_RD:
            begin
                op = status.z_done ? qmm_pkg::OP_NONE : qmm_pkg::OP_Z_RD;
            end
            qmm_pkg::ST_Z_CMP:    op = qmm_pkg::OP_Z_CMP;
            qmm_pkg::ST_Z_ADD:    op = qmm_pkg::OP_Z_ADD;
            qmm_pkg::ST_P_RD:
            begin
                if (!status.x_done)
                begin
                    op = qmm_pkg::OP_P_RD;
                end
                else if (status.merged)
                begin
                    op = qmm_pkg::OP_C_INIT;
                end
                else
                begin
                    op = qmm_pkg::OP_E_INIT;
                end
            end
            qmm_pkg::ST_P_CHK:    op = qmm_pkg::OP_P_CHK;
            qmm_pkg::ST_C_RD:
            begin
                op = status.c_done ? qmm_pkg::OP_C_END : qmm_pkg::OP_C_RD;
            end
            qmm_pkg::ST_C_WR:     op = qmm_pkg::OP_C_WR;
            qmm_pkg::ST_ESS:      op = qmm_pkg::OP_ESS;
            qmm_pkg::ST_SEL_INIT: op = qmm_pkg::OP_S_INIT;
            qmm_pkg::ST_PR_HEAD:
            begin
                if (status.pz_done)
                begin
                    op = qmm_pkg::OP_EM_INIT;
                end
                else if (status.ess_cur)
                begin
                    op = qmm_pkg::OP_PR_SKIP;
                end
                else
                begin
                    op = qmm_pkg::OP_PR_BEGIN;
                end
            end
            qmm_pkg::ST_PR_STEP:  op = qmm_pkg::OP_PR_STEP;
            qmm_pkg::ST_PR_END:   op = qmm_pkg::OP_PR_END;
            qmm_pkg::ST_EM_CHK:   op = qmm_pkg::OP_NONE;
            qmm_pkg::ST_EM_NONE:  op = qmm_pkg::OP_EM_NONE;
            qmm_pkg::ST_EMIT:
            begin
                op = status.pz_done ? qmm_pkg::OP_NONE : qmm_pkg::OP_EMIT;
            end
            default:              op = qmm_pkg::OP_NONE;
        endcase
    end

endmodule

@@ rtl/core/qmm_datapath.sv @@
// Datapath of the minimizer: implicant memories, prime registers, counters, output register.
module qmm_datapath #(
    parameter int MAX_VARS   = qmm_pkg::MAX_VARS_DEF,
    parameter int TERM_DEPTH = qmm_pkg::TERM_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qmm_pkg::op_t                  op,
    output qmm_pkg::status_t              status,
    input  logic [qmm_pkg::TABLE_W-1:0]   in_table,
    input  logic [qmm_pkg::VC_W-1:0]      in_var_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [qmm_pkg::OUT_W-1:0]     out_care,
    output logic [qmm_pkg::OUT_W-1:0]     out_lit,
    output logic [qmm_pkg::KIND_W-1:0]    out_kind,
    output logic                          out_ovf,
    output logic                          out_last
);

    localparam int VW      = MAX_VARS;
    localparam int TBL_LEN = 1 << MAX_VARS;
    localparam int AW      = $clog2(TERM_DEPTH);
    localparam int CW      = AW + 1;
    localparam int PD      = qmm_pkg::PRIME_DEPTH;
    localparam int PW      = qmm_pkg::PRIME_AW;

    // Control registers.
    logic [VW-1:0]      i_reg, i_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      nc_reg, nc_next;
    logic [CW-1:0]      x_reg, x_next;
    logic [CW-1:0]      y_reg, y_next;
    logic [CW-1:0]      z_reg, z_next;
    logic [PW:0]        pc_reg, pc_next;
    logic [PW:0]        pz_reg, pz_next;
    logic               x_hit_reg, x_hit_next;
    logic [PD-1:0]      ess_reg, ess_next;
    logic [PD-1:0]      sel_reg, sel_next;
    logic               merged_reg, merged_next;
    logic               ovf_reg, ovf_next;
    logic               flag_reg, flag_next;
    logic               ov_reg, ov_next;

    // Payload registers.
    logic [TBL_LEN-1:0] tbl_reg, tbl_next;
    logic [VW-1:0]      all_reg, all_next;
    logic [VW-1:0]      xv_reg, xv_next;
    logic [VW-1:0]      xm_reg, xm_next;
    logic [VW-1:0]      nv_reg, nv_next;
    logic [VW-1:0]      nm_reg, nm_next;
    logic [VW-1:0]      pv_reg [PD];
    logic [VW-1:0]      pv_next [PD];
    logic [VW-1:0]      pm_reg [PD];
    logic [VW-1:0]      pm_next [PD];
    logic [qmm_pkg::OUT_W-1:0]  care_reg, care_next;
    logic [qmm_pkg::OUT_W-1:0]  lit_reg, lit_next;
    logic [qmm_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic               oovf_reg, oovf_next;
    logic               last_reg, last_next;

    // Memory ports.
    logic               cur_we, nxt_we;
    logic [AW-1:0]      cur_waddr, cur_raddr, nxt_waddr, nxt_raddr;
    logic [2*VW-1:0]    cur_wdata, cur_rdata, nxt_wdata, nxt_rdata;
    logic               used_we;
    logic [AW-1:0]      used_waddr;
    logic               used_wdata, used_rdata;

    // Combinational helpers.
    logic [qmm_pkg::VC_W-1:0] n_clamp;
    logic [VW-1:0]      all_in;
    logic [TBL_LEN-1:0] tbl_raw;
    logic [TBL_LEN-1:0] tbl_in;
    logic [TBL_LEN-1:0] used_bits;
    logic [VW-1:0]      rd_val, rd_mask, diff;
    logic               merge_ok, z_match, p_found, mt_one, cover_res, out_free;
    logic [PD-1:0]      pvalid, mt, trial, higher;
    logic [PW-1:0]      pzi;

    qmm_ram #(.WIDTH(2 * VW), .DEPTH(TERM_DEPTH)) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    qmm_ram #(.WIDTH(2 * VW), .DEPTH(TERM_DEPTH)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    // Merge flags of the current level; an entry is cleared when its implicant is written.
    qmm_ram #(.WIDTH(1), .DEPTH(TERM_DEPTH)) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (x_reg[AW-1:0]),
        .rdata (used_rdata)
    );

    // Table bits beyond the input word are always zero.
    for (genvar k = 0; k < TBL_LEN; k++)
    begin : g_tbl
        if (k < qmm_pkg::TABLE_W)
        begin : g_in
            assign tbl_raw[k] = in_table[k];
        end
        else
        begin : g_zero
            assign tbl_raw[k] = 1'b0;
        end
    end

    always_comb
    begin
        if (in_var_count == '0)
        begin
            n_clamp = qmm_pkg::VC_W'(1);
        end
        else if (in_var_count > qmm_pkg::VC_W'(MAX_VARS))
        begin
            n_clamp = qmm_pkg::VC_W'(MAX_VARS);
        end
        else
        begin
            n_clamp = in_var_count;
        end
        all_in = VW'((32'd1 << n_clamp) - 32'd1);
        for (int k = 0; k < TBL_LEN; k++)
        begin
            tbl_in[k]    = tbl_raw[k] && (VW'(k) <= all_in);
            used_bits[k] = (VW'(k) <= all_reg);
        end
    end

    assign rd_mask  = cur_rdata[2*VW-1:VW];
    assign rd_val   = cur_rdata[VW-1:0];
    assign diff     = (xv_reg ^ rd_val) & xm_reg;
    assign merge_ok = (rd_mask == xm_reg) && ((xm_reg & (xm_reg - 1'b1)) != '0)
                      && (diff != '0) && ((diff & (diff - 1'b1)) == '0);
    assign z_match  = (nxt_rdata == {nm_reg, nv_reg});
    assign pzi      = pz_reg[PW-1:0];
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        p_found = 1'b0;
        for (int j = 0; j < PD; j++)
        begin
            pvalid[j] = ((PW + 1)'(j) < pc_reg);
            mt[j]     = pvalid[j] && ((i_reg & pm_reg[j]) == pv_reg[j]);
            higher[j] = ((PW + 1)'(j) > pz_reg);
            if (pvalid[j] && (pv_reg[j] == rd_val) && (pm_reg[j] == rd_mask))
            begin
                p_found = 1'b1;
            end
        end
        mt_one    = (mt != '0) && ((mt & (mt - 1'b1)) == '0);
        trial     = sel_reg & ~(PD'(1) << pzi);
        cover_res = |(trial & mt);
    end

    always_comb
    begin
        status.tbl_zero = (tbl_reg == '0);
        status.tbl_full = (tbl_reg == used_bits);
        status.i_last   = (i_reg == all_reg);
        status.x_done   = (x_reg >= cnt_reg);
        status.y_done   = (y_reg >= cnt_reg);
        status.z_done   = (z_reg >= nc_reg);
        status.merge_ok = merge_ok;
        status.z_match  = z_match;
        status.c_done   = (x_reg >= nc_reg);
        status.merged   = merged_reg;
        status.pz_done  = (pz_reg >= pc_reg);
        status.ess_cur  = ess_reg[pzi];
        status.sel_none = (sel_reg == '0);
        status.out_free = out_free;
    end

    always_comb
    begin
        i_next      = i_reg;
        cnt_next    = cnt_reg;
        nc_next     = nc_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        pc_next     = pc_reg;
        pz_next     = pz_reg;
        x_hit_next  = x_hit_reg;
        ess_next    = ess_reg;
        sel_next    = sel_reg;
        merged_next = merged_reg;
        ovf_next    = ovf_reg;
        flag_next   = flag_reg;
        tbl_next    = tbl_reg;
        all_next    = all_reg;
        xv_next     = xv_reg;
        xm_next     = xm_reg;
        nv_next     = nv_reg;
        nm_next     = nm_reg;
        pv_next     = pv_reg;
        pm_next     = pm_reg;
        care_next   = care_reg;
        lit_next    = lit_reg;
        kind_next   = kind_reg;
        oovf_next   = oovf_reg;
        last_next   = last_reg;
        ov_next     = ov_reg && !out_ready;

        cur_we     = 1'b0;
        cur_waddr  = cnt_reg[AW-1:0];
        cur_wdata  = {all_reg, i_reg};
        cur_raddr  = x_reg[AW-1:0];
        nxt_we     = 1'b0;
        nxt_waddr  = nc_reg[AW-1:0];
        nxt_wdata  = {nm_reg, nv_reg};
        nxt_raddr  = z_reg[AW-1:0];
        used_we    = 1'b0;
        used_waddr = x_reg[AW-1:0];
        used_wdata = 1'b0;

        unique case (op)
            qmm_pkg::OP_NONE:
            begin
            end
            qmm_pkg::OP_START:
            begin
                tbl_next = tbl_in;
                all_next = all_in;
                ovf_next = 1'b0;
                cnt_next = '0;
                pc_next  = '0;
                i_next   = '0;
            end
            qmm_pkg::OP_CONST:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    care_next = '0;
                    lit_next  = '0;
                    kind_next = (tbl_reg == '0) ? qmm_pkg::KIND_FALSE : qmm_pkg::KIND_TRUE;
                    oovf_next = 1'b0;
                    last_next = 1'b1;
                end
            end
            qmm_pkg::OP_LOAD:
            begin
                if (tbl_reg[i_reg])
                begin
                    if (cnt_reg < CW'(TERM_DEPTH))
                    begin
                        cur_we     = 1'b1;
                        used_we    = 1'b1;
                        used_waddr = cnt_reg[AW-1:0];
                        cnt_next   = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                i_next = i_reg + 1'b1;
            end
            qmm_pkg::OP_LVL:
            begin
                nc_next     = '0;
                merged_next = 1'b0;
                x_next      = '0;
            end
            qmm_pkg::OP_X_RD:
            begin
                cur_raddr = x_reg[AW-1:0];
            end
            qmm_pkg::OP_X_LAT:
            begin
                xv_next    = rd_val;
                xm_next    = rd_mask;
                y_next     = x_reg + 1'b1;
                x_hit_next = 1'b0;
            end
            qmm_pkg::OP_X_NEXT:
            begin
                // The x entry is flagged, if it merged with any y entry, once its pairing pass is over.
                if (x_hit_reg)
                begin
                    used_we    = 1'b1;
                    used_waddr = x_reg[AW-1:0];
                    used_wdata = 1'b1;
                end
                x_next = x_reg + 1'b1;
            end
            qmm_pkg::OP_Y_RD:
            begin
                cur_raddr = y_reg[AW-1:0];
            end
            qmm_pkg::OP_Y_CMP:
            begin
                if (merge_ok)
                begin
                    used_we     = 1'b1;
                    used_waddr  = y_reg[AW-1:0];
                    used_wdata  = 1'b1;
                    x_hit_next  = 1'b1;
                    merged_next = 1'b1;
                    nm_next     = xm_reg & ~diff;
                    nv_next     = xv_reg & ~diff;
                    z_next      = '0;
                end
                else
                begin
                    y_next = y_reg + 1'b1;
                end
            end
            qmm_pkg::OP_Z_RD:
            begin
                nxt_raddr = z_reg[AW-1:0];
            end
            qmm_pkg::OP_Z_CMP:
            begin
                if (z_match)
                begin
                    y_next = y_reg + 1'b1;
                end
                else
                begin
                    z_next = z_reg + 1'b1;
                end
            end
            qmm_pkg::OP_Z_ADD:
            begin
                if (nc_reg < CW'(TERM_DEPTH))
                begin
                    nxt_we  = 1'b1;
                    nc_next = nc_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                y_next = y_reg + 1'b1;
            end
            qmm_pkg::OP_P_INIT:
            begin
                x_next = '0;
            end
            qmm_pkg::OP_P_RD:
            begin
                cur_raddr = x_reg[AW-1:0];
            end
            qmm_pkg::OP_P_CHK:
            begin
                if (!used_rdata && !p_found)
                begin
                    if (pc_reg < (PW + 1)'(PD))
                    begin
                        pv_next[pc_reg[PW-1:0]] = rd_val;
                        pm_next[pc_reg[PW-1:0]] = rd_mask;
                        pc_next = pc_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                x_next = x_reg + 1'b1;
            end
            qmm_pkg::OP_C_INIT:
            begin
                x_next = '0;
            end
            qmm_pkg::OP_C_RD:
            begin
                nxt_raddr = x_reg[AW-1:0];
            end
            qmm_pkg::OP_C_WR:
            begin
                cur_we     = 1'b1;
                cur_waddr  = x_reg[AW-1:0];
                cur_wdata  = nxt_rdata;
                used_we    = 1'b1;
                used_waddr = x_reg[AW-1:0];
                x_next     = x_reg + 1'b1;
            end
            qmm_pkg::OP_C_END:
            begin
                cnt_next = nc_reg;
            end
            qmm_pkg::OP_E_INIT:
            begin
                i_next   = '0;
                ess_next = '0;
            end
            qmm_pkg::OP_ESS:
            begin
                if (tbl_reg[i_reg] && mt_one)
                begin
                    ess_next = ess_reg | mt;
                end
                i_next = i_reg + 1'b1;
            end
            qmm_pkg::OP_S_INIT:
            begin
                sel_next = pvalid;
                pz_next  = '0;
            end
            qmm_pkg::OP_PR_BEGIN:
            begin
                flag_next = 1'b0;
                i_next    = '0;
            end
            qmm_pkg::OP_PR_STEP:
            begin
                if (cover_res != tbl_reg[i_reg])
                begin
                    flag_next = 1'b1;
                end
                i_next = i_reg + 1'b1;
            end
            qmm_pkg::OP_PR_END:
            begin
                sel_next[pzi] = flag_reg;
                pz_next       = pz_reg + 1'b1;
            end
            qmm_pkg::OP_PR_SKIP:
            begin
                pz_next = pz_reg + 1'b1;
            end
            qmm_pkg::OP_EM_INIT:
            begin
                pz_next = '0;
            end
            qmm_pkg::OP_EM_NONE:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    care_next = '0;
                    lit_next  = '0;
                    kind_next = qmm_pkg::KIND_TERM;
                    oovf_next = ovf_reg;
                    last_next = 1'b1;
                end
            end
            qmm_pkg::OP_EMIT:
            begin
                if (!sel_reg[pzi])
                begin
                    pz_next = pz_reg + 1'b1;
                end
                else if (out_free)
                begin
                    ov_next   = 1'b1;
                    care_next = qmm_pkg::OUT_W'(pm_reg[pzi]);
                    lit_next  = qmm_pkg::OUT_W'(pv_reg[pzi]);
                    kind_next = qmm_pkg::KIND_TERM;
                    oovf_next = ovf_reg;
                    last_next = ((sel_reg & higher) == '0);
                    pz_next   = pz_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg      <= '0;
            cnt_reg    <= '0;
            nc_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            z_reg      <= '0;
            pc_reg     <= '0;
            pz_reg     <= '0;
            x_hit_reg  <= 1'b0;
            ess_reg    <= '0;
            sel_reg    <= '0;
            merged_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            flag_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            i_reg      <= i_next;
            cnt_reg    <= cnt_next;
            nc_reg     <= nc_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            z_reg      <= z_next;
            pc_reg     <= pc_next;
            pz_reg     <= pz_next;
            x_hit_reg  <= x_hit_next;
            ess_reg    <= ess_next;
            sel_reg    <= sel_next;
            merged_reg <= merged_next;
            ovf_reg    <= ovf_next;
            flag_reg   <= flag_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg  <= tbl_next;
        all_reg  <= all_next;
        xv_reg   <= xv_next;
        xm_reg   <= xm_next;
        nv_reg   <= nv_next;
        nm_reg   <= nm_next;
        pv_reg   <= pv_next;
        pm_reg   <= pm_next;
        care_reg <= care_next;
        lit_reg  <= lit_next;
        kind_reg <= kind_next;
        oovf_reg <= oovf_next;
        last_reg <= last_next;
    end

    assign out_valid = ov_reg;
    assign out_care  = care_reg;
    assign out_lit   = lit_reg;
    assign out_kind  = kind_reg;
    assign out_ovf   = oovf_reg;
    assign out_last  = last_reg;

endmodule

@@ rtl/core/quine_mccluskey_minimizer.sv @@
// Top level of the two-level logic minimizer: sequencer, datapath and channel wiring.
//
//   Channel | Direction | Beat carries
//   --------+-----------+---------------------------------------------------------
//   items   | in        | table_bits (32), var_count (3): one whole truth table
//   terms   | out       | care_mask, literal_true, constant_kind, table_overflow,
//           |           | last_term: one product term of the cover
//
// One table is worked on at a time; a new table beat is taken only once the
// previous table has handed its last term to the output register.
// A constant table is answered with a single beat. Otherwise the load walks
// the 2^n table entries; each merge level pairs implicants and scans the next
// level for duplicates, reading one entry at a time, since the implicant
// memory has one read port; prime collection and level copy walk the entries,
// essential marking and the pruning of each non-essential prime the 2^n minterms.
// Emission walks the stored primes, one per cycle while the output is not stalled.
// Reset is asynchronous and clears only control state; the implicant memories
// need no clearing, and the merge flags of a level are cleared as its entries
// are written. A stalled output holds its term and stops the emitter,
// while earlier phases continue up to the first term.
module quine_mccluskey_minimizer #(
    parameter int MAX_VARS   = qmm_pkg::MAX_VARS_DEF,
    parameter int TERM_DEPTH = qmm_pkg::TERM_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    qmm_in_if.sink  items,
    qmm_out_if.source terms
);

    qmm_pkg::op_t     op;
    qmm_pkg::status_t status;

    // The sequencer owns the input handshake; the datapath owns the output register.
    qmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .status   (status),
        .op       (op)
    );

    qmm_datapath #(
        .MAX_VARS   (MAX_VARS),
        .TERM_DEPTH (TERM_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .status       (status),
        .in_table     (items.table_bits),
        .in_var_count (items.var_count),
        .out_valid    (terms.valid),
        .out_ready    (terms.ready),
        .out_care     (terms.care_mask),
        .out_lit      (terms.literal_true),
        .out_kind     (terms.constant_kind),
        .out_ovf      (terms.table_overflow),
        .out_last     (terms.last_term)
    );

endmodule

@@ rtl/core/qmm_checker.sv @@
// Port-level checks for the minimizer, bound to the top level.
module qmm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [qmm_pkg::OUT_W-1:0]     care_mask,
    input logic [qmm_pkg::OUT_W-1:0]     literal_true,
    input logic [qmm_pkg::KIND_W-1:0]    constant_kind,
    input logic                          table_overflow,
    input logic                          last_term
);

    // A stalled output beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({care_mask, literal_true, constant_kind,
                                             table_overflow, last_term}))
        else $error("output payload changed while stalled");

    // Taking a table makes the block busy on the next cycle.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second table taken back to back");

    // While a term that is not the last waits, no new table is taken.
    a_no_take_mid_cover: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_term |-> !in_ready)
        else $error("input ready in the middle of a cover");

    // A constant result is a single bare beat.
    a_const_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (constant_kind != qmm_pkg::KIND_TERM) |-> last_term && (care_mask == '0))
        else $error("constant result is not a single empty beat");

endmodule

bind quine_mccluskey_minimizer qmm_checker u_qmm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (items.valid),
    .in_ready       (items.ready),
    .out_valid      (terms.valid),
    .out_ready      (terms.ready),
    .care_mask      (terms.care_mask),
    .literal_true   (terms.literal_true),
    .constant_kind  (terms.constant_kind),
    .table_overflow (terms.table_overflow),
    .last_term      (terms.last_term)
);
